/* rtl/tdlu_pkg.sv */
`default_nettype none
package tdlu_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam logic [1:0] REQ_ROW    = 2'd0;
    localparam logic [1:0] REQ_FACTOR = 2'd1;
    localparam logic [1:0] REQ_SOLVE  = 2'd2;
    localparam logic [1:0] REQ_MULT   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_NOTF  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM  = 1'b1;

    typedef enum logic [24:0] {
        S_IDLE   = 25'h0000001,
        S_ONE    = 25'h0000002,
        S_F_LD   = 25'h0000004,
        S_F_LDD  = 25'h0000008,
        S_F_RD   = 25'h0000010,
        S_F_CHK  = 25'h0000020,
        S_F_DIV  = 25'h0000040,
        S_F_MUL  = 25'h0000080,
        S_F_ADD  = 25'h0000100,
        S_V_LD   = 25'h0000200,
        S_V_LDD  = 25'h0000400,
        S_S_RD   = 25'h0000800,
        S_S_MUL  = 25'h0001000,
        S_S_ADD  = 25'h0002000,
        S_B_RD   = 25'h0004000,
        S_B_DAT  = 25'h0008000,
        S_B_ADD  = 25'h0010000,
        S_B_DIV  = 25'h0020000,
        S_M_RD   = 25'h0040000,
        S_M_P1   = 25'h0080000,
        S_M_P2   = 25'h0100000,
        S_M_P3   = 25'h0200000,
        S_M_P4   = 25'h0400000,
        S_E_RD   = 25'h0800000,
        S_E_OUT  = 25'h1000000
    } state_t;

endpackage
`default_nettype wire

/* rtl/tridiagonal_lu_solver.sv */
// factor: one bit-serial divide per row dominates the elimination
// solve: forward substitution, then back substitution with the divider per element
// multiply: one product pass; either run then emits n results, index 0 first
// one item at a time; the single-result requests answer through S_ONE
// rst_n clears control state asynchronously; the row and vector memories are not
// cleared and hold nothing defined until written
`default_nettype none
module tridiagonal_lu_solver #(
    parameter int MAX_ROWS   = tdlu_pkg::MAX_ROWS_DEF,
    parameter int DATA_WIDTH = tdlu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // row_index, diag_value, upper_value, lower_value, vector_value, zero pad
    input  wire logic [tdlu_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,  // last_element
    input  wire logic [tdlu_pkg::S_TUSER_W-1:0] s_tuser,  // req_type
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // result_value, result_index, zero pad
    output logic      [tdlu_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                                m_tlast,  // result_last
    output logic      [tdlu_pkg::M_TUSER_W-1:0] m_tuser,  // status
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tdlu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tdlu_pkg::CFG_DAT_W-1:0] cfg_data
);
    import tdlu_pkg::*;

    localparam int EFF_W  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int FRAC_W = EFF_W - 8;
    localparam int AW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_ROWS + 1);
    localparam int DVD_W  = 32 + FRAC_W;
    localparam int DCW    = $clog2(DVD_W + 1);
    localparam logic signed [65:0] HI_W = (66'sd1 <<< (EFF_W - 1)) - 66'sd1;
    localparam logic signed [65:0] LO_W = -HI_W - 66'sd1;
    localparam logic signed [65:0] RND_W = 66'sd1 <<< (FRAC_W - 1);

    function automatic logic signed [65:0] sx(input logic signed [31:0] x);
        return {{34{x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] sat_v(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v > HI_W) ? HI_W : ((v < LO_W) ? LO_W : v);
        return r[31:0];
    endfunction

    function automatic logic sat_f(input logic signed [65:0] v);
        return (v > HI_W) || (v < LO_W);
    endfunction

    function automatic logic [31:0] mag(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : x;
    endfunction

    // input fields
    logic        [5:0]  in_idx;
    logic signed [31:0] in_diag, in_up, in_low, in_vec;
    assign in_idx  = s_tdata[5:0];
    assign in_diag = s_tdata[37:6];
    assign in_up   = s_tdata[69:38];
    assign in_low  = s_tdata[101:70];
    assign in_vec  = s_tdata[133:102];

    state_t state_reg, state_next;
    logic [AW-1:0] i_reg, i_next;
    logic [6:0] size_reg, size_next;
    logic sym_reg, sym_next;
    logic factored_reg, factored_next;
    logic sflag_reg, sflag_next;
    logic mode_reg, mode_next;              // 1 multiply run, 0 solve run
    logic [1:0] one_st_reg, one_st_next;

    logic signed [31:0] cur_piv_reg, cur_piv_next, nxt_reg, nxt_next;
    logic signed [31:0] up_r_reg, up_r_next, m_r_reg, m_r_next;
    logic signed [31:0] v_r_reg, v_r_next, w_r_reg, w_r_next, piv_r_reg, piv_r_next;
    logic signed [31:0] prev_w_reg, prev_w_next, x_nx_reg, x_nx_next;
    logic signed [31:0] v_cur_reg, v_cur_next, v_nx_reg, v_nx_next;
    logic signed [31:0] acc_reg, acc_next, w_cur_reg, w_cur_next;
    logic signed [63:0] prod_reg;

    logic out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic signed [31:0] out_val_reg, out_val_next;
    logic [5:0] out_idx_reg, out_idx_next;
    logic [1:0] out_st_reg, out_st_next;

    // memories
    logic piv_we, up_we, mul_we, work_we, vec_we;
    logic [AW-1:0] piv_wa, up_wa, mul_wa, work_wa, vec_wa;
    logic [AW-1:0] piv_ra, up_ra, mul_ra, work_ra, vec_ra;
    logic signed [31:0] piv_wd, up_wd, mul_wd, work_wd, vec_wd;
    logic signed [31:0] piv_rd, up_rd, mul_rd, work_rd, vec_rd;

    tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_piv (.clk(clk), .we(piv_we),
        .waddr(piv_wa), .wdata(piv_wd), .raddr(piv_ra), .rdata(piv_rd));
    tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_up (.clk(clk), .we(up_we),
        .waddr(up_wa), .wdata(up_wd), .raddr(up_ra), .rdata(up_rd));
    tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_mul (.clk(clk), .we(mul_we),
        .waddr(mul_wa), .wdata(mul_wd), .raddr(mul_ra), .rdata(mul_rd));
    tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_work (.clk(clk), .we(work_we),
        .waddr(work_wa), .wdata(work_wd), .raddr(work_ra), .rdata(work_rd));
    tdlu_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_vec (.clk(clk), .we(vec_we),
        .waddr(vec_wa), .wdata(vec_wd), .raddr(vec_ra), .rdata(vec_rd));

    // effective size and loop bounds
    logic [CW-1:0] n_eff;
    logic [AW-1:0] n_m1, n_m2, i_inc, i_dec;
    always_comb
    begin
        if (size_reg < 7'd2)
        begin
            n_eff = CW'(2);
        end
        else if (32'(size_reg) > MAX_ROWS)
        begin
            n_eff = CW'(MAX_ROWS);
        end
        else
        begin
            n_eff = CW'(size_reg);
        end
    end
    assign n_m1  = AW'(n_eff - CW'(1));
    assign n_m2  = AW'(n_eff - CW'(2));
    assign i_inc = i_reg + AW'(1);
    assign i_dec = i_reg - AW'(1);

    // shared multiplier, rounding and adder
    logic signed [31:0] mul_a, mul_b, add_a, add_b;
    logic add_sub;
    logic signed [65:0] rnd_w, sum_w;
    logic signed [31:0] pr_v, add_v;
    logic pr_f, add_f;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign rnd_w = ($signed({{2{prod_reg[63]}}, prod_reg}) + RND_W) >>> FRAC_W;
    assign pr_v  = sat_v(rnd_w);
    assign pr_f  = sat_f(rnd_w);
    assign sum_w = add_sub ? (sx(add_a) - sx(add_b)) : (sx(add_a) + sx(add_b));
    assign add_v = sat_v(sum_w);
    assign add_f = sat_f(sum_w);

    // bit-serial restoring divider, one quotient bit per cycle
    logic div_start;
    logic signed [31:0] div_a, div_b;
    logic [DCW-1:0] div_cnt_reg;
    logic [DVD_W-1:0] dvd_reg, quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic div_neg_reg, div_zero_reg;
    logic [32:0] rem_sh;
    logic div_ge, div_done;
    logic signed [65:0] div_w;
    logic signed [31:0] div_v;
    logic div_f;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge   = rem_sh >= {1'b0, dvs_reg};
    assign div_done = (div_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (div_start)
        begin
            div_cnt_reg <= DCW'(DVD_W);
        end
        else if (!div_done)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dvd_reg      <= {mag(div_a), {FRAC_W{1'b0}}};
            dvs_reg      <= mag(div_b);
            rem_reg      <= '0;
            quo_reg      <= '0;
            div_neg_reg  <= div_a[31] ^ div_b[31];
            div_zero_reg <= (div_b == 32'sd0);
        end
        else if (!div_done)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= div_ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
            quo_reg <= {quo_reg[DVD_W-2:0], div_ge};
        end
    end

    always_comb
    begin
        div_w = $signed({{(66 - DVD_W){1'b0}}, quo_reg});
        if (div_neg_reg)
        begin
            div_w = -div_w;
        end
        div_v = div_zero_reg ? 32'sd0 : sat_v(div_w);
        div_f = div_zero_reg ? 1'b0 : sat_f(div_w);
    end

    logic out_free;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        size_next     = size_reg;
        sym_next      = sym_reg;
        factored_next = factored_reg;
        sflag_next    = sflag_reg;
        mode_next     = mode_reg;
        one_st_next   = one_st_reg;
        cur_piv_next  = cur_piv_reg;
        nxt_next      = nxt_reg;
        up_r_next     = up_r_reg;
        m_r_next      = m_r_reg;
        v_r_next      = v_r_reg;
        w_r_next      = w_r_reg;
        piv_r_next    = piv_r_reg;
        prev_w_next   = prev_w_reg;
        x_nx_next     = x_nx_reg;
        v_cur_next    = v_cur_reg;
        v_nx_next     = v_nx_reg;
        acc_next      = acc_reg;
        w_cur_next    = w_cur_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_val_next  = out_val_reg;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;
        out_st_next   = out_st_reg;

        piv_we = 1'b0;  up_we = 1'b0;  mul_we = 1'b0;  work_we = 1'b0;  vec_we = 1'b0;
        piv_wa = i_reg; up_wa = i_reg; mul_wa = i_reg; work_wa = i_reg; vec_wa = i_reg;
        piv_ra = i_reg; up_ra = i_reg; mul_ra = i_reg; work_ra = i_reg; vec_ra = i_reg;
        piv_wd = add_v; up_wd = add_v; mul_wd = div_v; work_wd = add_v; vec_wd = add_v;

        mul_a = '0; mul_b = '0;
        add_a = '0; add_b = pr_v; add_sub = 1'b0;
        div_start = 1'b0; div_a = '0; div_b = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        REQ_ROW:
                        begin
                            piv_wa = in_idx[AW-1:0];
                            up_wa  = in_idx[AW-1:0];
                            mul_wa = in_idx[AW-1:0];
                            piv_wd = sat_v(sx(in_diag));
                            up_wd  = sat_v(sx(in_up));
                            mul_wd = sat_v(sx(sym_reg ? in_up : in_low));
                            piv_we = (32'(in_idx) < MAX_ROWS);
                            up_we  = piv_we;
                            mul_we = piv_we;
                            factored_next = 1'b0;
                        end
                        REQ_FACTOR:
                        begin
                            sflag_next = 1'b0;
                            if (factored_reg)
                            begin
                                one_st_next = ST_OK;
                                state_next  = S_ONE;
                            end
                            else
                            begin
                                state_next = S_F_LD;
                            end
                        end
                        default:
                        begin
                            vec_wa = in_idx[AW-1:0];
                            vec_wd = sat_v(sx(in_vec));
                            vec_we = (32'(in_idx) < MAX_ROWS);
                            if (s_tlast)
                            begin
                                if (!factored_reg)
                                begin
                                    one_st_next = ST_NOTF;
                                    state_next  = S_ONE;
                                end
                                else
                                begin
                                    sflag_next = 1'b0;
                                    mode_next  = (s_tuser == REQ_MULT);
                                    state_next = S_V_LD;
                                end
                            end
                        end
                    endcase
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = '0;
                    out_idx_next   = '0;
                    out_last_next  = 1'b1;
                    out_st_next    = one_st_reg;
                    state_next     = S_IDLE;
                end
            end
            // elimination
            S_F_LD:
            begin
                piv_ra = '0;
                state_next = S_F_LDD;
            end
            S_F_LDD:
            begin
                cur_piv_next = piv_rd;
                i_next       = '0;
                state_next   = S_F_RD;
            end
            S_F_RD:
            begin
                piv_ra = i_inc;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (cur_piv_reg == 32'sd0)
                begin
                    one_st_next = ST_ZERO;
                    state_next  = S_ONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = mul_rd;
                    div_b      = cur_piv_reg;
                    up_r_next  = up_rd;
                    nxt_next   = piv_rd;
                    state_next = S_F_DIV;
                end
            end
            S_F_DIV:
            begin
                if (div_done)
                begin
                    m_r_next   = div_v;
                    sflag_next = sflag_reg | div_f;
                    mul_we     = 1'b1;
                    state_next = S_F_MUL;
                end
            end
            S_F_MUL:
            begin
                mul_a = m_r_reg;
                mul_b = up_r_reg;
                state_next = S_F_ADD;
            end
            S_F_ADD:
            begin
                add_a   = nxt_reg;
                add_sub = 1'b1;
                piv_we  = 1'b1;
                piv_wa  = i_inc;
                cur_piv_next = add_v;
                sflag_next   = sflag_reg | pr_f | add_f;
                if (i_reg == n_m2)
                begin
                    if (add_v == 32'sd0)
                    begin
                        one_st_next = ST_ZERO;
                    end
                    else
                    begin
                        factored_next = 1'b1;
                        one_st_next = (sflag_reg | pr_f | add_f) ? ST_SAT : ST_OK;
                    end
                    state_next = S_ONE;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_F_RD;
                end
            end
            // first vector element for either run
            S_V_LD:
            begin
                vec_ra = '0;
                state_next = S_V_LDD;
            end
            S_V_LDD:
            begin
                if (mode_reg)
                begin
                    v_cur_next = vec_rd;
                    i_next     = '0;
                    state_next = S_M_RD;
                end
                else
                begin
                    prev_w_next = vec_rd;
                    work_we     = 1'b1;
                    work_wa     = '0;
                    work_wd     = vec_rd;
                    i_next      = AW'(1);
                    state_next  = S_S_RD;
                end
            end
            // forward substitution
            S_S_RD:
            begin
                mul_ra = i_dec;
                state_next = S_S_MUL;
            end
            S_S_MUL:
            begin
                mul_a    = mul_rd;
                mul_b    = prev_w_reg;
                v_r_next = vec_rd;
                state_next = S_S_ADD;
            end
            S_S_ADD:
            begin
                add_a      = v_r_reg;
                add_sub    = 1'b1;
                work_we    = 1'b1;
                prev_w_next = add_v;
                sflag_next = sflag_reg | pr_f | add_f;
                if (i_reg == n_m1)
                begin
                    state_next = S_B_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_S_RD;
                end
            end
            // back substitution
            S_B_RD:
            begin
                state_next = S_B_DAT;
            end
            S_B_DAT:
            begin
                piv_r_next = piv_rd;
                w_r_next   = work_rd;
                if (i_reg == n_m1)
                begin
                    div_start  = 1'b1;
                    div_a      = work_rd;
                    div_b      = piv_rd;
                    state_next = S_B_DIV;
                end
                else
                begin
                    mul_a      = up_rd;
                    mul_b      = x_nx_reg;
                    state_next = S_B_ADD;
                end
            end
            S_B_ADD:
            begin
                add_a      = w_r_reg;
                add_sub    = 1'b1;
                sflag_next = sflag_reg | pr_f | add_f;
                div_start  = 1'b1;
                div_a      = add_v;
                div_b      = piv_r_reg;
                state_next = S_B_DIV;
            end
            S_B_DIV:
            begin
                if (div_done)
                begin
                    work_we    = 1'b1;
                    work_wd    = div_v;
                    x_nx_next  = div_v;
                    sflag_next = sflag_reg | div_f;
                    if (i_reg == '0)
                    begin
                        state_next = S_E_RD;
                    end
                    else
                    begin
                        i_next     = i_dec;
                        state_next = S_B_RD;
                    end
                end
            end
            // product run
            S_M_RD:
            begin
                vec_ra = i_inc;
                mul_ra = i_dec;
                state_next = S_M_P1;
            end
            S_M_P1:
            begin
                mul_a     = piv_rd;
                mul_b     = v_cur_reg;
                up_r_next = up_rd;
                v_nx_next = vec_rd;
                m_r_next  = mul_rd;
                state_next = S_M_P2;
            end
            S_M_P2:
            begin
                acc_next   = pr_v;
                sflag_next = sflag_reg | pr_f;
                mul_a      = up_r_reg;
                mul_b      = v_nx_reg;
                state_next = S_M_P3;
            end
            S_M_P3:
            begin
                add_a = acc_reg;
                if (i_reg == n_m1)
                begin
                    w_cur_next = acc_reg;
                end
                else
                begin
                    w_cur_next = add_v;
                    sflag_next = sflag_reg | pr_f | add_f;
                end
                mul_a      = m_r_reg;
                mul_b      = prev_w_reg;
                state_next = S_M_P4;
            end
            S_M_P4:
            begin
                add_a   = w_cur_reg;
                work_we = 1'b1;
                if (i_reg == '0)
                begin
                    work_wd = w_cur_reg;
                end
                else
                begin
                    sflag_next = sflag_reg | pr_f | add_f;
                end
                prev_w_next = w_cur_reg;
                v_cur_next  = v_nx_reg;
                if (i_reg == n_m1)
                begin
                    i_next     = '0;
                    state_next = S_E_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_M_RD;
                end
            end
            // results out, index 0 first
            S_E_RD:
            begin
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = work_rd;
                    out_idx_next   = 6'(i_reg);
                    out_last_next  = (i_reg == n_m1);
                    out_st_next    = sflag_reg ? ST_SAT : ST_OK;
                    if (i_reg == n_m1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_E_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SIZE:
                begin
                    size_next     = cfg_data;
                    factored_next = 1'b0;
                end
                CFG_SYM:
                begin
                    sym_next = cfg_data[0];
                end
                default:
                begin
                    sym_next = sym_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            size_reg      <= 7'd64;
            sym_reg       <= 1'b0;
            factored_reg  <= 1'b0;
            sflag_reg     <= 1'b0;
            mode_reg      <= 1'b0;
            one_st_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            size_reg      <= size_next;
            sym_reg       <= sym_next;
            factored_reg  <= factored_next;
            sflag_reg     <= sflag_next;
            mode_reg      <= mode_next;
            one_st_reg    <= one_st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_piv_reg  <= cur_piv_next;
        nxt_reg      <= nxt_next;
        up_r_reg     <= up_r_next;
        m_r_reg      <= m_r_next;
        v_r_reg      <= v_r_next;
        w_r_reg      <= w_r_next;
        piv_r_reg    <= piv_r_next;
        prev_w_reg   <= prev_w_next;
        x_nx_reg     <= x_nx_next;
        v_cur_reg    <= v_cur_next;
        v_nx_reg     <= v_nx_next;
        acc_reg      <= acc_next;
        w_cur_reg    <= w_cur_next;
        out_val_reg  <= out_val_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_st_reg   <= out_st_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_idx_reg, out_val_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_st_reg;

endmodule
`default_nettype wire

/* rtl/tdlu_ram.sv */
`default_nettype none
module tdlu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
